// ===== rtl/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  // Configuration register indexes
  localparam logic REG_HEAP_LIMIT = 1'b0;

  // Reset value of the heap limit register
  localparam logic [16:0] HEAP_LIMIT_RST = 17'h10000;

  typedef struct packed {
    logic        kind;
    logic [16:0] req_size;
    logic [15:0] free_addr;
  } ffba_in_t;

  typedef struct packed {
    logic [15:0] user_addr;
    logic [5:0]  block_index;
    logic [2:0]  status;
  } ffba_out_t;

  // One block table entry as kept in the table memory
  typedef struct packed {
    logic [15:0] base;
    logic [16:0] bytes;
    logic        free;
  } ffba_entry_t;

  localparam int unsigned ENTRY_W = $bits(ffba_entry_t);

endpackage

// ===== rtl/ffba_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module ffba_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/first_fit_block_allocator_unit.sv =====
// First-fit block allocator: block table walk, append at bump pointer, and free by address.
// Flow: a request walks the table from entry zero until an entry matches; a free that matches
//   nothing reports unknown, and an allocate that finds no fit appends at the bump pointer or fails.
// Zero-size allocates, null frees and frees on an empty table answer without a table walk.
// Throughput: one word at a time; the next is accepted the cycle after the result loads.
// Reset clears the entry count and bump pointer, sets heap_limit to 65536; table not cleared.
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ffba_in_t    in_word_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ffba_out_t   out_word_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned NEED_W = 18;
  // Hard cap on the bump pointer: HEAP_BYTES, and never past a 16-bit user address
  localparam logic [16:0] LIM_CAP = 17'((HEAP_BYTES < 65536) ? HEAP_BYTES : 65536);
  localparam logic [6:0]  HDR     = 7'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MISS = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic              kind_q, kind_d;
  logic [16:0]       size_q, size_d;
  logic [15:0]       addr_q, addr_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [IDX_W-1:0]  chk_q, chk_d;
  ffba_out_t         res_q, res_d;
  ffba_out_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [16:0]       bump_q, bump_d;
  logic [16:0]       limit_q;

  // table memory port
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  ffba_entry_t       mem_wdata, mem_rdata;

  // scan helpers
  logic              hit, last;
  logic [16:0]       lim_eff;
  logic              cfg_wr;

  ffba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Configuration: a single heap_limit register at byte address 0
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEAP_LIMIT);
  assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? {15'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= HEAP_LIMIT_RST;
    end else if (cfg_wr) begin
      limit_q <= pwdata[16:0];
    end
  end

  assign lim_eff = (limit_q < LIM_CAP) ? limit_q : LIM_CAP;

  // ---------------------------------------------------------------------------
  // Scan compare on the entry returned by the memory this cycle
  // ---------------------------------------------------------------------------
  // Allocate wants the first free entry big enough; free wants the matching user address.
  assign hit  = (kind_q == KIND_ALLOC)
              ? (mem_rdata.free && (mem_rdata.bytes >= size_q))
              : (({1'b0, mem_rdata.base} + 17'(HDR)) == {1'b0, addr_q});
  assign last = (chk_q == IDX_W'(count_q - CNT_W'(1)));

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    size_d      = size_q;
    addr_d      = addr_q;
    need_d      = need_q;
    chk_d       = chk_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    bump_d      = bump_q;
    mem_we      = 1'b0;
    mem_waddr   = chk_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    // drop the result word once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = in_word_i.kind;
          size_d = in_word_i.req_size;
          addr_d = in_word_i.free_addr;
          need_d = NEED_W'(bump_q) + NEED_W'(HDR) + NEED_W'(in_word_i.req_size);
          chk_d  = '0;
          if (in_word_i.kind == KIND_ALLOC && in_word_i.req_size == 17'd0) begin
            res_d   = '{user_addr: '0, block_index: '0, status: ST_ZERO};
            state_d = S_DONE;
          end else if (in_word_i.kind == KIND_FREE && in_word_i.free_addr == 16'd0) begin
            res_d   = '{user_addr: '0, block_index: '0, status: ST_OK};
            state_d = S_DONE;
          end else if (count_q == '0) begin
            if (in_word_i.kind == KIND_FREE) begin
              res_d   = '{user_addr: '0, block_index: '0, status: ST_UNKNOWN};
              state_d = S_DONE;
            end else begin
              state_d = S_MISS;
            end
          end else begin
            // start the walk at entry zero
            mem_re  = 1'b1;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          // mark used on allocate, free on free; base and size stay
          mem_we         = 1'b1;
          mem_waddr      = chk_q;
          mem_wdata.free = (kind_q == KIND_FREE);
          res_d.block_index = 6'(chk_q);
          res_d.status      = ST_OK;
          res_d.user_addr   = (kind_q == KIND_ALLOC) ? (mem_rdata.base + 16'(HDR)) : 16'd0;
          state_d = S_DONE;
        end else if (last) begin
          if (kind_q == KIND_FREE) begin
            res_d   = '{user_addr: '0, block_index: '0, status: ST_UNKNOWN};
            state_d = S_DONE;
          end else begin
            state_d = S_MISS;
          end
        end else begin
          // advance to the next entry
          mem_re    = 1'b1;
          mem_raddr = chk_q + IDX_W'(1);
          chk_d     = chk_q + IDX_W'(1);
        end
      end

      S_MISS: begin
        // no free block fits: append at the bump pointer if table and heap allow
        if (count_q == CNT_MAX) begin
          res_d = '{user_addr: '0, block_index: '0, status: ST_FULL};
        end else if (need_q > NEED_W'(lim_eff)) begin
          res_d = '{user_addr: '0, block_index: '0, status: ST_EXHAUSTED};
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = count_q[IDX_W-1:0];
          mem_wdata.base  = bump_q[15:0];
          mem_wdata.bytes = size_q;
          mem_wdata.free  = 1'b0;
          bump_d          = need_q[16:0];
          count_d         = count_q + CNT_W'(1);
          res_d.user_addr   = bump_q[15:0] + 16'(HDR);
          res_d.block_index = 6'(count_q);
          res_d.status      = ST_OK;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      bump_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      bump_q      <= bump_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    size_q <= size_d;
    addr_q <= addr_d;
    need_q <= need_d;
    chk_q  <= chk_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("entry count beyond table depth");

  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= LIM_CAP)
    else $error("bump pointer beyond heap cap");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("table read and write hit the same entry");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (bump_q > $past(bump_q)))
    else $error("new entry without bump pointer advance");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(chk_q) < count_q))
    else $error("scan index past last entry");

endmodule
